// File: src/tlwb_pkg.sv
package tlwb_pkg;

  localparam int CFG_INDEX_W = 3;
  localparam int COST_W      = 8;
  localparam int ACC_COST_W  = 11;
  localparam int NUM_CFG     = 6;

  localparam logic [CFG_INDEX_W-1:0] CFG_L1_READ    = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_L1_WRITE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_L2_READ    = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_L2_WRITE   = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRAM_READ  = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_DRAM_WRITE = 3'd5;

  localparam logic [COST_W-1:0] RST_L1_READ    = 8'd1;
  localparam logic [COST_W-1:0] RST_L1_WRITE   = 8'd1;
  localparam logic [COST_W-1:0] RST_L2_READ    = 8'd10;
  localparam logic [COST_W-1:0] RST_L2_WRITE   = 8'd10;
  localparam logic [COST_W-1:0] RST_DRAM_READ  = 8'd100;
  localparam logic [COST_W-1:0] RST_DRAM_WRITE = 8'd100;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_L1_CHK,
    ST_L2_RD,
    ST_L2_CHK,
    ST_FILL,
    ST_XFER,
    ST_L1_FILL,
    ST_WREAD,
    ST_WORD
  } state_t;

  typedef enum logic [1:0] {
    PASS_FILL,
    PASS_L2_TO_TMP,
    PASS_L1_TO_L2,
    PASS_TMP_TO_L1
  } pass_kind_t;

  typedef struct packed {
    logic       clear;
    logic       accept;
    logic       l1_check;
    logic       l2_base_ld;
    logic       l2_base_victim;
    logic       l2_wr;
    logic       l2_check;
    logic       pass_start;
    pass_kind_t pass_kind;
    logic       l1_fill_meta;
    logic       word_op;
  } ctrl_cmd_t;

  typedef struct packed {
    logic clr_done;
    logic l1_hit;
    logic l1_victim_dirty;
    logic l2_hit;
    logic pass_done;
    logic out_free;
  } ctrl_sts_t;

endpackage

// File: src/tlwb_ctrl.sv
module tlwb_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  tlwb_pkg::ctrl_sts_t sts,
  output tlwb_pkg::ctrl_cmd_t cmd
);
  import tlwb_pkg::*;

  state_t state_r, state_nxt;
  logic   phase_r, phase_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      phase_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      phase_r <= phase_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    phase_nxt = phase_r;
    cmd       = '0;
    cmd.l2_wr = phase_r;
    in_stall  = (state_r != ST_IDLE);
    unique case (state_r)
      ST_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          state_nxt  = ST_L1_CHK;
        end
      end
      ST_L1_CHK: begin
        cmd.l1_check = 1'b1;
        if (sts.l1_hit) begin
          if (sts.out_free) begin
            cmd.word_op = 1'b1;
            state_nxt   = ST_IDLE;
          end
        end else begin
          cmd.l2_base_ld = 1'b1;
          phase_nxt      = 1'b0;
          state_nxt      = ST_L2_RD;
        end
      end
      ST_L2_RD: begin
        state_nxt = ST_L2_CHK;
      end
      ST_L2_CHK: begin
        cmd.l2_check   = 1'b1;
        cmd.pass_start = 1'b1;
        if (sts.l2_hit) begin
          cmd.pass_kind = phase_r ? PASS_L1_TO_L2 : PASS_L2_TO_TMP;
          state_nxt     = ST_XFER;
        end else begin
          cmd.pass_kind = PASS_FILL;
          state_nxt     = ST_FILL;
        end
      end
      ST_FILL: begin
        if (sts.pass_done) begin
          cmd.pass_start = 1'b1;
          cmd.pass_kind  = phase_r ? PASS_L1_TO_L2 : PASS_L2_TO_TMP;
          state_nxt      = ST_XFER;
        end
      end
      ST_XFER: begin
        if (sts.pass_done) begin
          if (!phase_r && sts.l1_victim_dirty) begin
            phase_nxt          = 1'b1;
            cmd.l2_base_ld     = 1'b1;
            cmd.l2_base_victim = 1'b1;
            state_nxt          = ST_L2_RD;
          end else begin
            cmd.pass_start = 1'b1;
            cmd.pass_kind  = PASS_TMP_TO_L1;
            state_nxt      = ST_L1_FILL;
          end
        end
      end
      ST_L1_FILL: begin
        if (sts.pass_done) begin
          cmd.l1_fill_meta = 1'b1;
          state_nxt        = ST_WREAD;
        end
      end
      ST_WREAD: begin
        state_nxt = ST_WORD;
      end
      ST_WORD: begin
        if (sts.out_free) begin
          cmd.word_op = 1'b1;
          state_nxt   = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

endmodule

// File: src/tlwb_dp.sv
module tlwb_dp #(
  parameter int LINE_OFFSET_WIDTH  = 6,
  parameter int L1_INDEX_WIDTH     = 8,
  parameter int L2_SET_INDEX_WIDTH = 8,
  parameter int STORE_ADDR_WIDTH   = 16
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  tlwb_pkg::ctrl_cmd_t                  cmd,
  output tlwb_pkg::ctrl_sts_t                  sts,
  input  logic                                 in_action,
  input  logic [15:0]                          in_word_address,
  input  logic [31:0]                          in_write_data,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [31:0]                          out_read_data,
  output logic                                 out_l1_hit,
  output logic [1:0]                           out_l2_hit_count,
  output logic [1:0]                           out_dram_read_count,
  output logic [1:0]                           out_dram_write_count,
  output logic [10:0]                          out_access_cost,
  input  logic                                 cfg_write_en,
  input  logic [tlwb_pkg::CFG_INDEX_W-1:0]     cfg_index,
  input  logic [tlwb_pkg::COST_W-1:0]          cfg_data
);
  import tlwb_pkg::*;

  localparam int WOFF_W   = LINE_OFFSET_WIDTH - 2;
  localparam int SA_W     = STORE_ADDR_WIDTH;
  localparam int BLK_W    = SA_W - WOFF_W;
  localparam int L1T_W    = BLK_W - L1_INDEX_WIDTH;
  localparam int L2T_W    = BLK_W - L2_SET_INDEX_WIDTH;
  localparam int L1_LINES = 1 << L1_INDEX_WIDTH;
  localparam int L2_SETS  = 1 << L2_SET_INDEX_WIDTH;
  localparam int WPL      = 1 << WOFF_W;
  localparam int L1D_AW   = L1_INDEX_WIDTH + WOFF_W;
  localparam int L2D_AW   = L2_SET_INDEX_WIDTH + 1 + WOFF_W;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [L1T_W-1:0] tag;
  } l1_meta_t;

  typedef struct packed {
    logic             valid;
    logic             dirty;
    logic [L2T_W-1:0] tag;
  } l2_way_t;

  typedef struct packed {
    logic          lru;
    l2_way_t [1:0] way;
  } l2_meta_t;

  logic [31:0] l1_data_mem [(1 << L1D_AW)];
  logic [31:0] l2_data_mem [(1 << L2D_AW)];
  logic [31:0] dram_mem    [(1 << SA_W)];
  logic [31:0] tmp_mem     [WPL];
  l1_meta_t    l1_meta_mem [L1_LINES];
  l2_meta_t    l2_meta_mem [L2_SETS];

  logic [COST_W-1:0] cost_r [NUM_CFG];

  logic [SA_W-1:0]   addr_r;
  logic              wr_r;
  logic [31:0]       wdata_r;
  logic              hit_r;
  logic [L1T_W-1:0]  l1_vtag_r;
  logic              l1_vdirty_r;
  logic [BLK_W-1:0]  blk_r;
  logic              way_r;
  logic [L2T_W-1:0]  l2_vtag_r;
  logic              l2_vdirty_r;

  logic              act_r;
  logic [WOFF_W-1:0] cnt_r;
  pass_kind_t        kind_r;
  logic              wv_r;
  logic [WOFF_W-1:0] ww_r;
  logic [SA_W-1:0]   clr_r;

  logic [1:0]            hits_r, dr_r, dw_r;
  logic [ACC_COST_W-1:0] acc_r;

  logic [31:0] l1_rd_r, l2_rd_r, dram_rd_r, tmp_rd_r;
  l1_meta_t    l1_meta_rd_r;
  l2_meta_t    l2_meta_rd_r;

  logic                      out_valid_r;
  logic [31:0]               out_read_data_r;
  logic                      out_l1_hit_r;
  logic [1:0]                out_hits_r, out_dr_r, out_dw_r;
  logic [ACC_COST_W-1:0]     out_cost_r;

  logic [SA_W-1:0]               in_addr;
  logic [L1T_W-1:0]              tag1;
  logic [L1_INDEX_WIDTH-1:0]     idx;
  logic [WOFF_W-1:0]             woff;
  logic [L2_SET_INDEX_WIDTH-1:0] set2;
  logic [L2T_W-1:0]              tag2;
  logic                          l1_hit_c;
  logic                          h0, h1, l2_hit_c, way_c, l2_vdirty_c;
  l2_way_t                       vict_c;
  l2_meta_t                      l2_meta_new;
  logic [ACC_COST_W-1:0]         l2_cost_c;
  logic                          out_free;

  assign in_addr = SA_W'(in_word_address);
  assign tag1    = addr_r[SA_W-1 -: L1T_W];
  assign idx     = addr_r[WOFF_W +: L1_INDEX_WIDTH];
  assign woff    = addr_r[WOFF_W-1:0];
  assign set2    = blk_r[L2_SET_INDEX_WIDTH-1:0];
  assign tag2    = blk_r[BLK_W-1 -: L2T_W];

  assign l1_hit_c = l1_meta_rd_r.valid && (l1_meta_rd_r.tag == tag1);

  always_comb begin
    h0       = l2_meta_rd_r.way[0].valid && (l2_meta_rd_r.way[0].tag == tag2);
    h1       = l2_meta_rd_r.way[1].valid && (l2_meta_rd_r.way[1].tag == tag2);
    l2_hit_c = h0 || h1;
    priority if (h0) begin
      way_c = 1'b0;
    end else if (h1) begin
      way_c = 1'b1;
    end else if (!l2_meta_rd_r.way[0].valid) begin
      way_c = 1'b0;
    end else if (!l2_meta_rd_r.way[1].valid) begin
      way_c = 1'b1;
    end else begin
      way_c = ~l2_meta_rd_r.lru;
    end
    vict_c      = l2_meta_rd_r.way[way_c];
    l2_vdirty_c = !l2_hit_c && vict_c.valid && vict_c.dirty;
    l2_meta_new = l2_meta_rd_r;
    l2_meta_new.lru              = way_c;
    l2_meta_new.way[way_c].valid = 1'b1;
    l2_meta_new.way[way_c].tag   = tag2;
    l2_meta_new.way[way_c].dirty = l2_hit_c ? (vict_c.dirty | cmd.l2_wr) : cmd.l2_wr;
    l2_cost_c = ACC_COST_W'(cmd.l2_wr ? cost_r[CFG_L2_WRITE] : cost_r[CFG_L2_READ]);
    if (!l2_hit_c) begin
      l2_cost_c = l2_cost_c + ACC_COST_W'(cost_r[CFG_DRAM_READ]);
    end
    if (l2_vdirty_c) begin
      l2_cost_c = l2_cost_c + ACC_COST_W'(cost_r[CFG_DRAM_WRITE]);
    end
  end

  assign out_free = !out_valid_r || !out_stall;

  assign sts.clr_done        = cmd.clear && (clr_r == '1);
  assign sts.l1_hit          = l1_hit_c;
  assign sts.l1_victim_dirty = l1_vdirty_r;
  assign sts.l2_hit          = l2_hit_c;
  assign sts.pass_done       = wv_r && (ww_r == '1);
  assign sts.out_free        = out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cost_r[CFG_L1_READ]    <= RST_L1_READ;
      cost_r[CFG_L1_WRITE]   <= RST_L1_WRITE;
      cost_r[CFG_L2_READ]    <= RST_L2_READ;
      cost_r[CFG_L2_WRITE]   <= RST_L2_WRITE;
      cost_r[CFG_DRAM_READ]  <= RST_DRAM_READ;
      cost_r[CFG_DRAM_WRITE] <= RST_DRAM_WRITE;
    end else if (cfg_write_en && (cfg_index < CFG_INDEX_W'(NUM_CFG))) begin
      cost_r[cfg_index] <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      cnt_r  <= '0;
      kind_r <= PASS_FILL;
      wv_r   <= 1'b0;
      ww_r   <= '0;
      clr_r  <= '0;
    end else begin
      wv_r <= act_r;
      ww_r <= cnt_r;
      if (cmd.pass_start) begin
        act_r  <= 1'b1;
        cnt_r  <= '0;
        kind_r <= cmd.pass_kind;
      end else if (act_r) begin
        if (cnt_r == '1) begin
          act_r <= 1'b0;
        end
        cnt_r <= cnt_r + 1'b1;
      end
      if (cmd.clear) begin
        clr_r <= clr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      addr_r  <= in_addr;
      wr_r    <= in_action;
      wdata_r <= in_write_data;
    end
    if (cmd.l1_check) begin
      hit_r       <= l1_hit_c;
      l1_vtag_r   <= l1_meta_rd_r.tag;
      l1_vdirty_r <= l1_meta_rd_r.valid && l1_meta_rd_r.dirty;
    end
    if (cmd.l2_base_ld) begin
      blk_r <= cmd.l2_base_victim ? {l1_vtag_r, idx} : addr_r[SA_W-1:WOFF_W];
    end
    if (cmd.l2_check) begin
      way_r       <= way_c;
      l2_vtag_r   <= vict_c.tag;
      l2_vdirty_r <= l2_vdirty_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      hits_r <= '0;
      dr_r   <= '0;
      dw_r   <= '0;
      acc_r  <= '0;
    end else if (cmd.l2_check) begin
      acc_r <= acc_r + l2_cost_c;
      if (l2_hit_c) begin
        hits_r <= hits_r + 2'd1;
      end else begin
        dr_r <= dr_r + 2'd1;
      end
      if (l2_vdirty_c) begin
        dw_r <= dw_r + 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      l1_meta_mem[clr_r[L1_INDEX_WIDTH-1:0]] <= '0;
    end else if (cmd.l1_fill_meta) begin
      l1_meta_mem[idx] <= '{valid: 1'b1, dirty: 1'b0, tag: tag1};
    end else if (cmd.word_op && wr_r) begin
      l1_meta_mem[idx] <= '{valid: 1'b1, dirty: 1'b1, tag: tag1};
    end
    l1_meta_rd_r <= l1_meta_mem[cmd.accept ? in_addr[WOFF_W +: L1_INDEX_WIDTH] : idx];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      l2_meta_mem[clr_r[L2_SET_INDEX_WIDTH-1:0]] <= '0;
    end else if (cmd.l2_check) begin
      l2_meta_mem[set2] <= l2_meta_new;
    end
    l2_meta_rd_r <= l2_meta_mem[set2];
  end

  always_ff @(posedge clk) begin
    if (wv_r && (kind_r == PASS_TMP_TO_L1)) begin
      l1_data_mem[{idx, ww_r}] <= tmp_rd_r;
    end else if (cmd.word_op && wr_r) begin
      l1_data_mem[{idx, woff}] <= wdata_r;
    end
    if (act_r && (kind_r == PASS_L1_TO_L2)) begin
      l1_rd_r <= l1_data_mem[{idx, cnt_r}];
    end else if (cmd.accept) begin
      l1_rd_r <= l1_data_mem[in_addr[L1D_AW-1:0]];
    end else begin
      l1_rd_r <= l1_data_mem[{idx, woff}];
    end
  end

  always_ff @(posedge clk) begin
    if (wv_r && (kind_r == PASS_FILL)) begin
      l2_data_mem[{set2, way_r, ww_r}] <= dram_rd_r;
    end else if (wv_r && (kind_r == PASS_L1_TO_L2)) begin
      l2_data_mem[{set2, way_r, ww_r}] <= l1_rd_r;
    end
    l2_rd_r <= l2_data_mem[{set2, way_r, cnt_r}];
  end

  always_ff @(posedge clk) begin
    if (cmd.clear) begin
      dram_mem[clr_r] <= '0;
    end else if (wv_r && (kind_r == PASS_FILL) && l2_vdirty_r) begin
      dram_mem[{l2_vtag_r, set2, ww_r}] <= l2_rd_r;
    end
    dram_rd_r <= dram_mem[{blk_r, cnt_r}];
  end

  always_ff @(posedge clk) begin
    if (wv_r && (kind_r == PASS_L2_TO_TMP)) begin
      tmp_mem[ww_r] <= l2_rd_r;
    end
    tmp_rd_r <= tmp_mem[cnt_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.word_op) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.word_op) begin
      out_read_data_r <= wr_r ? 32'd0 : l1_rd_r;
      out_l1_hit_r    <= cmd.l1_check ? l1_hit_c : hit_r;
      out_hits_r      <= hits_r;
      out_dr_r        <= dr_r;
      out_dw_r        <= dw_r;
      out_cost_r      <= acc_r + ACC_COST_W'(wr_r ? cost_r[CFG_L1_WRITE]
                                                  : cost_r[CFG_L1_READ]);
    end
  end

  assign out_valid            = out_valid_r;
  assign out_read_data        = out_read_data_r;
  assign out_l1_hit           = out_l1_hit_r;
  assign out_l2_hit_count     = out_hits_r;
  assign out_dram_read_count  = out_dr_r;
  assign out_dram_write_count = out_dw_r;
  assign out_access_cost      = out_cost_r;

endmodule

// File: src/two_level_write_back_cache.sv
// Operation: one transaction at a time; in_stall is high until the controller is
// back in idle. An L1 hit does the tag check and the word access, which waits while
// out_stall holds a result. A miss makes, per L2 access, a tag read and lookup, a
// DRAM fill of the L2 line on an L2 miss, and a block copy (L2 to a buffer, or a dirty
// L1 victim into L2), then refills the L1 and does the word. Reset: a clearing pass
// walks every store address and the tag memories; no transaction is accepted meanwhile.
module two_level_write_back_cache #(
  parameter int LINE_OFFSET_WIDTH  = 6,
  parameter int L1_INDEX_WIDTH     = 8,
  parameter int L2_SET_INDEX_WIDTH = 8,
  parameter int STORE_ADDR_WIDTH   = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_action,
  input  logic [15:0]                      in_word_address,
  input  logic [31:0]                      in_write_data,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic [31:0]                      out_read_data,
  output logic                             out_l1_hit,
  output logic [1:0]                       out_l2_hit_count,
  output logic [1:0]                       out_dram_read_count,
  output logic [1:0]                       out_dram_write_count,
  output logic [10:0]                      out_access_cost,
  input  logic                             cfg_write_en,
  input  logic [tlwb_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [tlwb_pkg::COST_W-1:0]      cfg_data
);
  import tlwb_pkg::*;

  ctrl_cmd_t cmd;
  ctrl_sts_t sts;

  tlwb_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  tlwb_dp #(
    .LINE_OFFSET_WIDTH  (LINE_OFFSET_WIDTH),
    .L1_INDEX_WIDTH     (L1_INDEX_WIDTH),
    .L2_SET_INDEX_WIDTH (L2_SET_INDEX_WIDTH),
    .STORE_ADDR_WIDTH   (STORE_ADDR_WIDTH)
  ) u_dp (
    .clk                  (clk),
    .rst_n                (rst_n),
    .cmd                  (cmd),
    .sts                  (sts),
    .in_action            (in_action),
    .in_word_address      (in_word_address),
    .in_write_data        (in_write_data),
    .out_valid            (out_valid),
    .out_stall            (out_stall),
    .out_read_data        (out_read_data),
    .out_l1_hit           (out_l1_hit),
    .out_l2_hit_count     (out_l2_hit_count),
    .out_dram_read_count  (out_dram_read_count),
    .out_dram_write_count (out_dram_write_count),
    .out_access_cost      (out_access_cost),
    .cfg_write_en         (cfg_write_en),
    .cfg_index            (cfg_index),
    .cfg_data             (cfg_data)
  );

endmodule
